[rtl/dp2p_pkg.sv]
// Shared constants, register codes and types for the depth-pixel-to-point core.
package dp2p_pkg;

    localparam int DEPTH_W        = 16;
    localparam int PIX_W          = 12;
    localparam int COORD_W        = 24;
    localparam int DMAG_W         = 15;
    localparam int FIELD_W        = 16;
    localparam int FRAC_SHIFT     = 18;
    localparam int DEPTH_MIN      = 50;
    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int LIMITS_W       = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_INTR  = 3'd0,
        REG_XFORM_X   = 3'd1,
        REG_XFORM_Y   = 3'd2,
        REG_XFORM_Z   = 3'd3,
        REG_LIMITS    = 3'd4
    } cfg_reg_t;

    // Sideband that rides along the divider pipeline.
    typedef struct packed {
        logic              ok;
        logic              neg_x;
        logic              neg_y;
        logic [DMAG_W-1:0] depth;
    } div_side_t;

endpackage

[rtl/dp2p_pixel_if.sv]
// Request channel carrying one depth pixel.
interface dp2p_pixel_if;
    import dp2p_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DEPTH_W-1:0] depth_mm;
    logic [PIX_W-1:0]          pixel_row;
    logic [PIX_W-1:0]          pixel_col;

    modport source (output valid, depth_mm, pixel_row, pixel_col, input ready);
    modport sink   (input valid, depth_mm, pixel_row, pixel_col, output ready);
endinterface

[rtl/dp2p_point_if.sv]
// Request channel carrying one transformed 3-D point.
interface dp2p_point_if;
    import dp2p_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      point_valid;

    modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

[rtl/dp2p_div.sv]
// Dual-lane pipelined restoring divider, one quotient bit per stage.
module dp2p_div #(
    parameter int NUM_W = 35
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              num_x,
    input  logic [NUM_W-1:0]              num_y,
    input  logic [dp2p_pkg::FIELD_W-1:0]  den_x,
    input  logic [dp2p_pkg::FIELD_W-1:0]  den_y,
    input  dp2p_pkg::div_side_t           in_side,
    output logic                          out_valid,
    output logic [NUM_W-1:0]              quot_x,
    output logic [NUM_W-1:0]              quot_y,
    output dp2p_pkg::div_side_t           out_side
);
    import dp2p_pkg::*;

    localparam int DEN_W = FIELD_W;

    logic                 v_reg    [NUM_W];
    logic [DEN_W-1:0]     remx_reg [NUM_W];
    logic [DEN_W-1:0]     remy_reg [NUM_W];
    logic [NUM_W-1:0]     nx_reg   [NUM_W];
    logic [NUM_W-1:0]     ny_reg   [NUM_W];
    div_side_t            side_reg [NUM_W];

    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] num,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_n;
        logic             qbit;
        trial = {rem, num[NUM_W-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
        begin
            rem_n = diff[DEN_W-1:0];
            qbit  = 1'b1;
        end
        else
        begin
            rem_n = trial[DEN_W-1:0];
            qbit  = 1'b0;
        end
        return {rem_n, num[NUM_W-2:0], qbit};
    endfunction

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic                 v_in;
        logic [DEN_W-1:0]     rx_in;
        logic [DEN_W-1:0]     ry_in;
        logic [NUM_W-1:0]     nx_in;
        logic [NUM_W-1:0]     ny_in;
        div_side_t            s_in;
        logic [DEN_W+NUM_W-1:0] stx_next;
        logic [DEN_W+NUM_W-1:0] sty_next;

        if (i == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign rx_in = '0;
            assign ry_in = '0;
            assign nx_in = num_x;
            assign ny_in = num_y;
            assign s_in  = in_side;
        end
        else
        begin : g_rest
            assign v_in  = v_reg[i-1];
            assign rx_in = remx_reg[i-1];
            assign ry_in = remy_reg[i-1];
            assign nx_in = nx_reg[i-1];
            assign ny_in = ny_reg[i-1];
            assign s_in  = side_reg[i-1];
        end

        assign stx_next = div_step(rx_in, nx_in, den_x);
        assign sty_next = div_step(ry_in, ny_in, den_y);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {remx_reg[i], nx_reg[i]} <= stx_next;
                {remy_reg[i], ny_reg[i]} <= sty_next;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quot_x    = nx_reg[NUM_W-1];
    assign quot_y    = ny_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

[rtl/depth_pixel_to_point_core.sv]
// Top level: depth pixel back-projection and rigid transform pipeline.
// One depth pixel enters per clock and one point leaves per clock while the output
// is not stalled. Between acceptance and the point lie stages 0 to 2, the bit-per-stage
// divider for x and y, and stages 3 to 7; NUM_W = max(COORD_BITS+5, 17) + 18.
// The whole pipeline advances together whenever the output register is empty or
// taken, so a stalled downstream holds every stage and nothing is dropped.
// Configuration registers are read live by the stages. The user must write them only
// while the pipeline is empty; the block itself does not enforce this.
module depth_pixel_to_point_core #(
    parameter int COORD_BITS = dp2p_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [dp2p_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dp2p_pkg::CFG_DATA_W-1:0] cfg_data,
    dp2p_pixel_if.sink                      pixel,
    dp2p_point_if.source                    point
);
    import dp2p_pkg::*;

    // Datapath widths, all following from COORD_BITS.
    localparam int DX_W  = (COORD_BITS + 5 > 17) ? COORD_BITS + 5 : 17;
    localparam int PM_W  = DX_W - 1 + DMAG_W;
    localparam int NUM_W = PM_W + 4;
    localparam int XC_W  = NUM_W + 1;
    localparam int ZC_W  = DMAG_W + 5;
    localparam int PZ_W  = FIELD_W + ZC_W;
    localparam int PX_W  = FIELD_W + XC_W;
    localparam int SUM_W = PX_W + 3;
    localparam int MM_W  = SUM_W - FRAC_SHIFT;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] cam_reg;
    logic [CFG_DATA_W-1:0] rowx_reg;
    logic [CFG_DATA_W-1:0] rowy_reg;
    logic [CFG_DATA_W-1:0] rowz_reg;
    logic [LIMITS_W-1:0]   lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg  <= '0;
            rowx_reg <= '0;
            rowy_reg <= '0;
            rowz_reg <= '0;
            lim_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAM_INTR: cam_reg  <= cfg_data;
                REG_XFORM_X:  rowx_reg <= cfg_data;
                REG_XFORM_Y:  rowy_reg <= cfg_data;
                REG_XFORM_Z:  rowz_reg <= cfg_data;
                REG_LIMITS:   lim_reg  <= cfg_data[LIMITS_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [FIELD_W-1:0]        fx, fy, cx, cy;
    logic signed [FIELD_W-1:0] max_x, max_y, max_z;

    assign fx    = cam_reg[63:48];
    assign fy    = cam_reg[47:32];
    assign cx    = cam_reg[31:16];
    assign cy    = cam_reg[15:0];
    assign max_x = lim_reg[47:32];
    assign max_y = lim_reg[31:16];
    assign max_z = lim_reg[15:0];

    // The whole pipe advances when the output slot is free or being taken.
    logic adv;
    logic v7_reg;
    assign adv         = !v7_reg || point.ready;
    assign pixel.ready = adv;

    // Stage 0: capture the pixel, masking indices to COORD_BITS.
    logic                      v0_reg;
    logic signed [DEPTH_W-1:0] depth0_reg;
    logic [COORD_BITS-1:0]     row0_reg, col0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            depth0_reg <= pixel.depth_mm;
            row0_reg   <= COORD_BITS'(pixel.pixel_row);
            col0_reg   <= COORD_BITS'(pixel.pixel_col);
        end
    end

    // Stage 1: depth gate, principal-point offsets split into sign and magnitude.
    logic                   ok1_next;
    logic signed [DX_W-1:0] dx1_next, dy1_next;
    logic signed [DX_W-1:0] ndx1_next, ndy1_next;
    logic                   v1_reg, ok1_reg, nx1_reg, ny1_reg;
    logic [DX_W-2:0]        mx1_reg, my1_reg;
    logic [DMAG_W-1:0]      dep1_reg;

    assign ok1_next = (depth0_reg > DEPTH_W'(DEPTH_MIN)) && (depth0_reg < max_x)
                      && (fx != '0) && (fy != '0);
    assign dx1_next = $signed(DX_W'({col0_reg, 4'b0})) - $signed(DX_W'(cx));
    assign dy1_next = $signed(DX_W'({row0_reg, 4'b0})) - $signed(DX_W'(cy));
    assign ndx1_next = -dx1_next;
    assign ndy1_next = -dy1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok1_reg  <= ok1_next;
            nx1_reg  <= dx1_next[DX_W-1];
            ny1_reg  <= dy1_next[DX_W-1];
            mx1_reg  <= dx1_next[DX_W-1] ? ndx1_next[DX_W-2:0] : dx1_next[DX_W-2:0];
            my1_reg  <= dy1_next[DX_W-1] ? ndy1_next[DX_W-2:0] : dy1_next[DX_W-2:0];
            dep1_reg <= depth0_reg[DMAG_W-1:0];
        end
    end

    // Stage 2: numerator magnitudes |offset| * depth; the extra *16 is a shift.
    logic              v2_reg;
    logic [PM_W-1:0]   px2_reg, py2_reg;
    div_side_t         side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px2_reg   <= PM_W'(mx1_reg * dep1_reg);
            py2_reg   <= PM_W'(my1_reg * dep1_reg);
            side2_reg <= '{ok: ok1_reg, neg_x: nx1_reg, neg_y: ny1_reg, depth: dep1_reg};
        end
    end

    // Divide by fx and fy, truncating toward zero on magnitudes.
    logic             vd;
    logic [NUM_W-1:0] qx, qy;
    div_side_t        sided;

    dp2p_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v2_reg),
        .num_x     ({px2_reg, 4'b0}),
        .num_y     ({py2_reg, 4'b0}),
        .den_x     (fx),
        .den_y     (fy),
        .in_side   (side2_reg),
        .out_valid (vd),
        .quot_x    (qx),
        .quot_y    (qy),
        .out_side  (sided)
    );

    // Stage 3: restore signs of camera x, y; z is depth in Q.4.
    logic                   v3_reg, ok3_reg;
    logic signed [XC_W-1:0] xc3_reg, yc3_reg;
    logic signed [ZC_W-1:0] zc3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok3_reg <= sided.ok;
            xc3_reg <= sided.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            yc3_reg <= sided.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            zc3_reg <= $signed({1'b0, sided.depth, 4'b0});
        end
    end

    // Stage 4: nine rotation products.
    logic                   v4_reg, ok4_reg;
    logic signed [PZ_W-1:0] az4_reg [3];
    logic signed [PX_W-1:0] bx4_reg [3];
    logic signed [PX_W-1:0] cy4_reg [3];
    logic [CFG_DATA_W-1:0]  rows [3];

    assign rows[0] = rowx_reg;
    assign rows[1] = rowy_reg;
    assign rows[2] = rowz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok4_reg <= ok3_reg;
            for (int r = 0; r < 3; r++)
            begin
                az4_reg[r] <= $signed(rows[r][63:48]) * zc3_reg;
                bx4_reg[r] <= $signed(rows[r][47:32]) * xc3_reg;
                cy4_reg[r] <= $signed(rows[r][31:16]) * yc3_reg;
            end
        end
    end

    // Stage 5: exact Q.18 sums a*z - b*x - c*y + t.
    logic                    v5_reg, ok5_reg;
    logic signed [SUM_W-1:0] p5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok5_reg <= ok4_reg;
            for (int r = 0; r < 3; r++)
            begin
                p5_reg[r] <= SUM_W'(az4_reg[r]) - SUM_W'(bx4_reg[r]) - SUM_W'(cy4_reg[r])
                             + $signed({{(SUM_W-FIELD_W-FRAC_SHIFT){rows[r][15]}},
                                        rows[r][15:0], {FRAC_SHIFT{1'b0}}});
            end
        end
    end

    // Stage 6: range checks on exact sums, truncate toward zero to whole mm.
    logic signed [SUM_W-1:0] lim_x, lim_y, lim_z;
    logic signed [SUM_W:0]   abs_y;
    logic                    bad6_next;
    logic signed [MM_W-1:0]  mm6_next [3];
    logic                    v6_reg, ok6_reg;
    logic signed [MM_W-1:0]  mm6_reg [3];

    assign lim_x = $signed({{(SUM_W-FIELD_W-FRAC_SHIFT){max_x[FIELD_W-1]}}, max_x,
                            {FRAC_SHIFT{1'b0}}});
    assign lim_y = $signed({{(SUM_W-FIELD_W-FRAC_SHIFT){max_y[FIELD_W-1]}}, max_y,
                            {FRAC_SHIFT{1'b0}}});
    assign lim_z = $signed({{(SUM_W-FIELD_W-FRAC_SHIFT){max_z[FIELD_W-1]}}, max_z,
                            {FRAC_SHIFT{1'b0}}});
    assign abs_y = p5_reg[1][SUM_W-1] ? -(SUM_W+1)'(p5_reg[1]) : (SUM_W+1)'(p5_reg[1]);
    assign bad6_next = (p5_reg[2] > lim_z) || (p5_reg[0] > lim_x)
                       || (abs_y > (SUM_W+1)'(lim_y));

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            mm6_next[r] = p5_reg[r][SUM_W-1:FRAC_SHIFT]
                          + MM_W'(p5_reg[r][SUM_W-1] && (p5_reg[r][FRAC_SHIFT-1:0] != '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok6_reg <= ok5_reg && !bad6_next;
            for (int r = 0; r < 3; r++)
                mm6_reg[r] <= mm6_next[r];
        end
    end

    // Stage 7: saturate to 24 bits, zero invalid points, hold for the consumer.
    localparam logic signed [MM_W-1:0] SAT_HI = MM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [MM_W-1:0] SAT_LO = -MM_W'(1 << (COORD_W - 1));

    logic signed [COORD_W-1:0] sat7_next [3];
    logic signed [COORD_W-1:0] out7_reg  [3];
    logic                      pv7_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (!ok6_reg)
                sat7_next[r] = '0;
            else if (mm6_reg[r] > SAT_HI)
                sat7_next[r] = SAT_HI[COORD_W-1:0];
            else if (mm6_reg[r] < SAT_LO)
                sat7_next[r] = SAT_LO[COORD_W-1:0];
            else
                sat7_next[r] = mm6_reg[r][COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (adv)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pv7_reg <= ok6_reg;
            for (int r = 0; r < 3; r++)
                out7_reg[r] <= sat7_next[r];
        end
    end

    assign point.valid       = v7_reg;
    assign point.point_x     = out7_reg[0];
    assign point.point_y     = out7_reg[1];
    assign point.point_z     = out7_reg[2];
    assign point.point_valid = pv7_reg;

`ifndef SYNTHESIS
    // A rejected point leaves as all zeros.
    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && !point.point_valid |->
            point.point_x == '0 && point.point_y == '0 && point.point_z == '0)
        else $error("invalid point with nonzero coordinates");

    // Intake only while the output slot drains.
    a_intake_follows_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.ready |-> !point.valid || point.ready)
        else $error("pixel taken while output stalled");

    // A new output only comes from a filled stage 6.
    a_out_from_stage6: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point.valid) |-> $past(v6_reg))
        else $error("output valid without upstream item");
`endif

endmodule

[test/depth_pixel_to_point_core_tb.sv]
// Self-checking testbench for the depth-pixel-to-point core.
`timescale 1ns / 100ps

module depth_pixel_to_point_core_tb;
    import dp2p_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT = 4000;      // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 250;       // long receiver hold-off
    localparam longint Q18_ONE = 262144;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               ok;
    } point_t;

    // Predicts one point per accepted pixel and checks the outgoing points in order.
    class point_scoreboard;
        logic [63:0] intr;
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [47:0] limits;
        point_t      pending_points[$];
        int          mismatches;

        function new();
            intr = '0;
            row_x = '0;
            row_y = '0;
            row_z = '0;
            limits = '0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] data);
            case (idx)
                REG_CAM_INTR: intr = data;
                REG_XFORM_X:  row_x = data;
                REG_XFORM_Y:  row_y = data;
                REG_XFORM_Z:  row_z = data;
                REG_LIMITS:   limits = data[47:0];
                default: ;
            endcase
        endfunction

        // Exact Q.18 sum of one row applied to (z, -x, -y).
        function longint transform(logic [63:0] r, longint zc, longint xc, longint yc);
            longint a;
            longint b;
            longint c;
            longint t;
            a = longint'($signed(r[63:48]));
            b = longint'($signed(r[47:32]));
            c = longint'($signed(r[31:16]));
            t = longint'($signed(r[15:0]));
            return a * zc - b * xc - c * yc + t * Q18_ONE;
        endfunction

        // Truncate toward zero to whole mm, then clamp to 24 bits.
        function logic [COORD_W-1:0] to_mm(longint q18);
            longint mm;
            mm = q18 / Q18_ONE;
            if (mm > 64'sd8388607) mm = 64'sd8388607;
            if (mm < -64'sd8388608) mm = -64'sd8388608;
            return mm[COORD_W-1:0];
        endfunction

        function void note_pixel(logic [DEPTH_W-1:0] d, logic [PIX_W-1:0] r,
                                 logic [PIX_W-1:0] c);
            point_t p;
            longint depth;
            longint prow;
            longint pcol;
            longint fx;
            longint fy;
            longint cx;
            longint cy;
            longint max_x;
            longint max_y;
            longint max_z;
            longint xc;
            longint yc;
            longint zc;
            longint px;
            longint py;
            longint pz;
            longint ay;
            p = '{x: '0, y: '0, z: '0, ok: 1'b0};
            depth = longint'($signed(d));
            prow = longint'(r & ((1 << COORD_BITS) - 1));
            pcol = longint'(c & ((1 << COORD_BITS) - 1));
            fx = longint'({48'd0, intr[63:48]});
            fy = longint'({48'd0, intr[47:32]});
            cx = longint'({48'd0, intr[31:16]});
            cy = longint'({48'd0, intr[15:0]});
            max_x = longint'($signed(limits[47:32]));
            max_y = longint'($signed(limits[31:16]));
            max_z = longint'($signed(limits[15:0]));
            // Gate on depth window and nonzero focal lengths.
            if (depth > DEPTH_MIN && depth < max_x && fx != 0 && fy != 0)
            begin
                zc = depth * 16;
                xc = ((pcol * 16 - cx) * depth * 16) / fx;
                yc = ((prow * 16 - cy) * depth * 16) / fy;
                px = transform(row_x, zc, xc, yc);
                py = transform(row_y, zc, xc, yc);
                pz = transform(row_z, zc, xc, yc);
                ay = py < 0 ? -py : py;
                // Range limits use the exact sums, before truncation.
                if (!(pz > max_z * Q18_ONE) && !(px > max_x * Q18_ONE)
                    && !(ay > max_y * Q18_ONE))
                begin
                    p.x = to_mm(px);
                    p.y = to_mm(py);
                    p.z = to_mm(pz);
                    p.ok = 1'b1;
                end
            end
            pending_points = {pending_points, p};
        endfunction

        function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z, logic ok);
            point_t want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%h y=%h z=%h valid=%b", x, y, z, ok);
                return;
            end
            want = pending_points.pop_front();
            if (want.x !== x || want.y !== y || want.z !== z || want.ok !== ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp x=%h y=%h z=%h v=%b, got x=%h y=%h z=%h v=%b",
                             want.x, want.y, want.z, want.ok, x, y, z, ok);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dp2p_pixel_if pixel_ch();
    dp2p_point_if point_ch();

    depth_pixel_to_point_core #(.COORD_BITS(COORD_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pixel_ch),
        .point(point_ch)
    );

    point_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int quiet_cycles;

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Note every accepted request and check every accepted point at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                sb.note_pixel(pixel_ch.depth_mm, pixel_ch.pixel_row, pixel_ch.pixel_col);
            if (point_ch.valid && point_ch.ready)
                sb.check_point(point_ch.point_x, point_ch.point_y, point_ch.point_z,
                               point_ch.point_valid);
        end
    end

    // Watchdog: end the run after too long with no handshake on either side.
    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (point_ch.valid && point_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("depth_pixel_to_point_core_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        point_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                point_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                point_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Write all five registers back to back, then drop the write enable.
    task automatic write_settings(logic [63:0] intr, logic [63:0] rx, logic [63:0] ry,
                                  logic [63:0] rz, logic [47:0] lim);
        logic [63:0] vals[5];
        cfg_reg_t idx;
        vals = '{intr, rx, ry, rz, {16'd0, lim}};
        for (int i = 0; i < 5; i++)
        begin
            idx = cfg_reg_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[i];
            sb.set_reg(idx, vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every expected point has come out, then let the pipeline settle.
    task automatic drain_points();
        while (sb.pending_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one request and hold it until it is taken.
    task automatic send_pixel(logic [DEPTH_W-1:0] d, logic [PIX_W-1:0] r,
                              logic [PIX_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.depth_mm <= d;
        pixel_ch.pixel_row <= r;
        pixel_ch.pixel_col <= c;
        do @(posedge clk); while (!pixel_ch.ready);
    endtask

    task automatic end_burst();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly depths inside the gate window, some full-range noise.
    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] d;
        int hi;
        hi = int'($signed(sb.limits[47:32]));
        if ($urandom_range(99) < 75 && hi > 52)
            d = DEPTH_W'($urandom_range(hi - 1, 49));
        else
            d = DEPTH_W'($urandom);
        send_pixel(d, PIX_W'($urandom), PIX_W'($urandom));
    endtask

    function automatic logic [15:0] q14(int lo_v, int hi_v);
        return 16'($signed($urandom_range(hi_v - lo_v, 0)) + lo_v);
    endfunction

    // A plausible camera: focal lengths a few hundred pixels, near-identity rotation.
    task automatic write_camera_like();
        logic [63:0] intr;
        intr = {16'($urandom_range(1000, 200) * 16 + $urandom_range(15)),
                16'($urandom_range(1000, 200) * 16 + $urandom_range(15)),
                16'($urandom_range(4095)), 16'($urandom_range(4095))};
        write_settings(intr,
                       {q14(15000, 17000), q14(-2000, 2000), q14(-2000, 2000), 16'($urandom)},
                       {q14(-2000, 2000), q14(15000, 17000), q14(-2000, 2000), 16'($urandom)},
                       {q14(-2000, 2000), q14(-2000, 2000), q14(15000, 17000), 16'($urandom)},
                       {16'($urandom_range(32767, 1000)), 16'($urandom_range(32767, 500)),
                        16'($urandom_range(32767, 0))});
    endtask

    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 57;
        hold_req = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.depth_mm = '0;
        pixel_ch.pixel_row = '0;
        pixel_ch.pixel_col = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: zero focal length, every point invalid.
        send_pixel(16'sd1000, 12'd10, 12'd20);
        send_pixel(16'sh7FFF, 12'hFFF, 12'hFFF);
        end_burst();
        drain_points();

        // Directed: depth gate edges, pixel extremes, range limits.
        write_settings({16'd8000, 16'd8000, 16'd5120, 16'd3840},
                       {16'sd16384, 16'd0, 16'd0, 16'sd100},
                       {16'd0, 16'sd16384, 16'd0, -16'sd50},
                       {16'd0, 16'd0, 16'sd16384, 16'sd0},
                       {16'sd5000, 16'sd2000, 16'sd3000});
        send_pixel(16'sd50, 12'd240, 12'd320);
        send_pixel(16'sd51, 12'd240, 12'd320);
        send_pixel(16'sd4999, 12'd240, 12'd320);
        send_pixel(16'sd5000, 12'd240, 12'd320);
        send_pixel(16'sd0, 12'd0, 12'd0);
        send_pixel(-16'sd32768, 12'd0, 12'd0);
        send_pixel(16'sh7FFF, 12'hFFF, 12'hFFF);
        send_pixel(16'sd3000, 12'd0, 12'd0);
        send_pixel(16'sd3000, 12'hFFF, 12'hFFF);
        send_pixel(16'sd3000, 12'hFFF, 12'd0);
        send_pixel(16'sd4800, 12'd240, 12'd320);
        send_pixel(16'sd2000, 12'd2000, 12'd320);
        send_pixel(16'sd2000, 12'd240, 12'd3000);
        end_burst();
        drain_points();

        // Directed: small focal length and full-scale rotation drive saturation.
        write_settings({16'd1, 16'd1, 16'hFFFF, 16'd0},
                       {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF},
                       {16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000},
                       {16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF},
                       {16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_pixel(16'sh7FFE, 12'hFFF, 12'd0);
        send_pixel(16'sh7FFE, 12'd0, 12'hFFF);
        send_pixel(16'sd20000, 12'h800, 12'h800);
        send_pixel(16'sd60, 12'd1, 12'd1);
        end_burst();
        drain_points();

        // Random phases: several settings, three back-pressure regimes.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 23;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                4: write_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  48'({$urandom, $urandom}));
                7: write_settings('1, '1, '1, '1, '1);
                8: write_settings({16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
                                   16'($urandom), 16'($urandom)},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom},
                                  {16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
                default: write_camera_like();
            endcase
            for (int n = 0; n < 125; n++)
            begin
                // Hold off the receiver so the pipeline fills and stalls its input.
                if (ph == 2 && n == 30) hold_req = 1'b1;
                // Pause the sender until every expected point has come out.
                if (ph == 5 && n == 60)
                begin
                    end_burst();
                    while (sb.pending_points.size() != 0) @(posedge clk);
                end
                send_random_pixel();
            end
            end_burst();
            drain_points();
        end

        if (sb.mismatches == 0 && sb.pending_points.size() == 0)
            $display("depth_pixel_to_point_core_tb OK");
        else
            $display("depth_pixel_to_point_core_tb NOT OK");
        $finish;
    end
endmodule

[sim.f]
rtl/dp2p_pkg.sv
rtl/dp2p_pixel_if.sv
rtl/dp2p_point_if.sv
rtl/dp2p_div.sv
rtl/depth_pixel_to_point_core.sv
test/depth_pixel_to_point_core_tb.sv
